// ----- design/mab_pkg.sv -----
// ----------------------------------------------------------------------------
// mab_pkg: shared definitions for the max removal bag
// Request and status codes, field widths and the types handed along the row of
// cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mab_pkg;

   localparam int BAG_DEPTH_DEFAULT = 64;

   localparam int VALUE_W    = 32;
   localparam int REQ_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int FOUND_IDX_W = 6;
   localparam int COUNT_OUT_W = 7;
   localparam int CAP_OUT_W   = 8;

   localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
   localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic find_mode;
      logic write_en;
      logic shift_en;
   } cell_ctrl_type;

   typedef struct packed {
      logic                active;
      logic                flag;
      logic [VALUE_W-1:0]  value;
   } token_type;

endpackage

// ----- design/mab_if.sv -----
// ----------------------------------------------------------------------------
// mab_if: request and response channels of the max removal bag
// Valid and ready handshake channels with their payload fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mab_req_if;
   logic                                valid;
   logic                                ready;
   logic [mab_pkg::REQ_W-1:0]           req_type;
   logic signed [mab_pkg::VALUE_W-1:0]  value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface mab_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [mab_pkg::STATUS_W-1:0]          status;
   logic signed [mab_pkg::VALUE_W-1:0]    removed_value;
   logic                                  found;
   logic [mab_pkg::FOUND_IDX_W-1:0]       found_index;
   logic [mab_pkg::COUNT_OUT_W-1:0]       entry_count;
   logic [mab_pkg::CAP_OUT_W-1:0]         modelled_capacity;

   modport source (output valid, output status, output removed_value, output found,
                   output found_index, output entry_count, output modelled_capacity,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input found,
                   input found_index, input entry_count, input modelled_capacity,
                   output ready);
endinterface

// ----- design/mab_cell.sv -----
// ----------------------------------------------------------------------------
// mab_cell: one storage cell of the bag
// Holds one entry, takes a write of the key or a shift from its upper neighbor, and
// updates the search token that travels down the row one cell per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mab_cell #(
   parameter int IDX  = 0,
   parameter int CNTW = 7
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mab_pkg::cell_ctrl_type        ctrl,
   input  logic [CNTW-1:0]               count,
   input  logic [mab_pkg::VALUE_W-1:0]   key,
   input  logic [CNTW-1:0]               shift_idx,
   input  logic [mab_pkg::VALUE_W-1:0]   next_entry,
   input  mab_pkg::token_type            tok_in,
   input  logic [CNTW-1:0]               tok_idx_in,
   output logic [mab_pkg::VALUE_W-1:0]   entry,
   output mab_pkg::token_type            tok_out,
   output logic [CNTW-1:0]               tok_idx_out
);

   localparam logic [CNTW-1:0] MY_IDX   = CNTW'(IDX);
   localparam logic [CNTW-1:0] NEXT_IDX = CNTW'(IDX + 1);

   logic [mab_pkg::VALUE_W-1:0] entry_ff;
   mab_pkg::token_type          tok_ff;
   mab_pkg::token_type          tok_in_c;
   logic [CNTW-1:0]             tok_idx_ff;
   logic [CNTW-1:0]             tok_idx_in_c;
   logic                        occupied;
   logic                        take;

   assign occupied = MY_IDX < count;

   always_comb begin
      if (ctrl.find_mode) begin
         take = occupied && !tok_in.flag && (entry_ff == key);
      end else begin
         take = occupied && (!tok_in.flag || ($signed(entry_ff) > $signed(tok_in.value)));
      end
      tok_in_c     = tok_in;
      tok_idx_in_c = tok_idx_in;
      if (take) begin
         tok_in_c.flag  = 1'b1;
         tok_in_c.value = entry_ff;
         tok_idx_in_c   = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write_en && (MY_IDX == count)) begin
         entry_ff <= key;
      end else if (ctrl.shift_en && (MY_IDX >= shift_idx) && (NEXT_IDX < count)) begin
         entry_ff <= next_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_c.active;
      end
      tok_ff.flag  <= tok_in_c.flag;
      tok_ff.value <= tok_in_c.value;
      tok_idx_ff   <= tok_idx_in_c;
   end

   assign entry       = entry_ff;
   assign tok_out     = tok_ff;
   assign tok_idx_out = tok_idx_ff;

endmodule

// ----- design/max_removal_bag.sv -----
// ----------------------------------------------------------------------------
// max_removal_bag: unordered bag with removal of the largest value
// A request is accepted in ST_IDLE and decoded in ST_EXEC; a find, or a remove
// on a nonempty bag, then waits in ST_SWEEP for the search token, a remove also
// passes ST_SHIFT, and ST_DONE loads the response register. The next request
// can be taken in the cycle after the response is loaded. A search token walks
// the row of cells one cell per cycle; one request is in work at a time, while
// a response may wait.
// Synchronous reset empties the bag and sets the modelled capacity to two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_removal_bag #(
   parameter int BAG_DEPTH = mab_pkg::BAG_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mab_req_if.sink      req,
   mab_rsp_if.source    rsp
);

   localparam int CNTW = $clog2(BAG_DEPTH + 1);
   localparam int CAPW = $clog2(BAG_DEPTH) + 2;
   localparam logic [CNTW-1:0] FULL_COUNT = CNTW'(BAG_DEPTH);
   localparam logic [CAPW-1:0] CAP_MIN    = CAPW'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SWEEP,
      ST_SHIFT,
      ST_DONE
   } state_type;

   state_type                               state_ff;
   logic [mab_pkg::REQ_W-1:0]               op_ff;
   logic [mab_pkg::VALUE_W-1:0]             key_ff;
   logic [CNTW-1:0]                         count_ff;
   logic [CAPW-1:0]                         cap_ff;
   logic [CNTW-1:0]                         shift_idx_ff;
   logic [mab_pkg::STATUS_W-1:0]            res_status_ff;
   logic [mab_pkg::VALUE_W-1:0]             res_removed_ff;
   logic                                    res_found_ff;
   logic [CNTW-1:0]                         res_idx_ff;
   logic                                    rsp_valid_ff;
   logic [mab_pkg::STATUS_W-1:0]            rsp_status_ff;
   logic [mab_pkg::VALUE_W-1:0]             rsp_removed_ff;
   logic                                    rsp_found_ff;
   logic [mab_pkg::FOUND_IDX_W-1:0]         rsp_idx_ff;
   logic [mab_pkg::COUNT_OUT_W-1:0]         rsp_count_ff;
   logic [mab_pkg::CAP_OUT_W-1:0]           rsp_cap_ff;

   mab_pkg::cell_ctrl_type                  ctrl;
   logic                                    full;
   logic                                    start;
   logic [CNTW-1:0]                         count_dec;
   logic [CAPW-1:0]                         count_wide;
   logic [CAPW-1:0]                         count_dec_wide;
   logic [CNTW+mab_pkg::FOUND_IDX_W-1:0]    idx_ext;
   logic [CNTW+mab_pkg::COUNT_OUT_W-1:0]    count_ext;
   logic [CAPW+mab_pkg::CAP_OUT_W-1:0]      cap_ext;

   logic [mab_pkg::VALUE_W-1:0]             entry   [BAG_DEPTH];
   mab_pkg::token_type                      tok     [BAG_DEPTH+1];
   logic [CNTW-1:0]                         tok_idx [BAG_DEPTH+1];

   assign full           = count_ff == FULL_COUNT;
   assign count_dec      = count_ff - CNTW'(1);
   assign count_wide     = CAPW'(count_ff);
   assign count_dec_wide = CAPW'(count_dec);
   assign start          = (state_ff == ST_EXEC) &&
                           ((op_ff == mab_pkg::REQ_FIND) ||
                            ((op_ff == mab_pkg::REQ_REMOVE) && (count_ff != '0)));

   always_comb begin
      ctrl.find_mode = op_ff == mab_pkg::REQ_FIND;
      ctrl.write_en  = (state_ff == ST_EXEC) && (op_ff == mab_pkg::REQ_ADD) && !full;
      ctrl.shift_en  = state_ff == ST_SHIFT;
   end

   always_comb begin
      tok[0].active = start;
      tok[0].flag   = 1'b0;
      tok[0].value  = '0;
      tok_idx[0]    = '0;
   end

   for (genvar i = 0; i < BAG_DEPTH; i++) begin : g_cell
      logic [mab_pkg::VALUE_W-1:0] next_entry;
      if (i == BAG_DEPTH - 1) begin : g_last
         assign next_entry = entry[i];
      end else begin : g_mid
         assign next_entry = entry[i+1];
      end
      mab_cell #(
         .IDX  (i),
         .CNTW (CNTW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .count       (count_ff),
         .key         (key_ff),
         .shift_idx   (shift_idx_ff),
         .next_entry  (next_entry),
         .tok_in      (tok[i]),
         .tok_idx_in  (tok_idx[i]),
         .entry       (entry[i]),
         .tok_out     (tok[i+1]),
         .tok_idx_out (tok_idx[i+1])
      );
   end

   assign idx_ext   = {{mab_pkg::FOUND_IDX_W{1'b0}}, res_idx_ff};
   assign count_ext = {{mab_pkg::COUNT_OUT_W{1'b0}}, count_ff};
   assign cap_ext   = {{mab_pkg::CAP_OUT_W{1'b0}}, cap_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CAP_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req.valid) begin
                  op_ff    <= req.req_type;
                  key_ff   <= req.value;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               res_removed_ff <= '0;
               res_found_ff   <= 1'b0;
               res_idx_ff     <= '0;
               case (op_ff)
                  mab_pkg::REQ_ADD: begin
                     state_ff <= ST_DONE;
                     if (full) begin
                        res_status_ff <= mab_pkg::STATUS_FULL;
                     end else begin
                        res_status_ff <= mab_pkg::STATUS_OK;
                        count_ff      <= count_ff + CNTW'(1);
                        if (count_wide == (cap_ff >> 1)) begin
                           cap_ff <= cap_ff << 1;
                        end
                     end
                  end
                  mab_pkg::REQ_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_ff <= mab_pkg::STATUS_EMPTY;
                        state_ff      <= ST_DONE;
                     end else begin
                        res_status_ff <= mab_pkg::STATUS_OK;
                        state_ff      <= ST_SWEEP;
                     end
                  end
                  mab_pkg::REQ_FIND: begin
                     res_status_ff <= mab_pkg::STATUS_OK;
                     state_ff      <= ST_SWEEP;
                  end
                  default: begin
                     res_status_ff <= mab_pkg::STATUS_OK;
                     state_ff      <= ST_DONE;
                  end
               endcase
            end
            ST_SWEEP: begin
               if (tok[BAG_DEPTH].active) begin
                  if (op_ff == mab_pkg::REQ_FIND) begin
                     res_found_ff <= tok[BAG_DEPTH].flag;
                     res_idx_ff   <= tok[BAG_DEPTH].flag ? tok_idx[BAG_DEPTH] : '0;
                     state_ff     <= ST_DONE;
                  end else begin
                     res_removed_ff <= tok[BAG_DEPTH].value;
                     shift_idx_ff   <= tok_idx[BAG_DEPTH];
                     state_ff       <= ST_SHIFT;
                  end
               end
            end
            ST_SHIFT: begin
               count_ff <= count_dec;
               if ((count_dec_wide < (cap_ff >> 2)) && (cap_ff > CAP_MIN)) begin
                  cap_ff <= cap_ff >> 1;
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_removed_ff <= res_removed_ff;
                  rsp_found_ff   <= res_found_ff;
                  rsp_idx_ff     <= idx_ext[mab_pkg::FOUND_IDX_W-1:0];
                  rsp_count_ff   <= count_ext[mab_pkg::COUNT_OUT_W-1:0];
                  rsp_cap_ff     <= cap_ext[mab_pkg::CAP_OUT_W-1:0];
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req.ready             = state_ff == ST_IDLE;
   assign rsp.valid             = rsp_valid_ff;
   assign rsp.status            = rsp_status_ff;
   assign rsp.removed_value     = rsp_removed_ff;
   assign rsp.found             = rsp_found_ff;
   assign rsp.found_index       = rsp_idx_ff;
   assign rsp.entry_count       = rsp_count_ff;
   assign rsp.modelled_capacity = rsp_cap_ff;

endmodule
